@@ rtl/paged_memory_manager_defines.svh @@
// Assertion macros for the paged memory manager.
// Used only by the top level; no other dependencies.
`ifndef PAGED_MEMORY_MANAGER_DEFINES_SVH
`define PAGED_MEMORY_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
`define PMM_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PMM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PMM_ASSERT_IMPL(label, clk, rst, a, c)
`define PMM_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/pmm_pkg.sv @@
// Shared types and constants of the paged memory manager.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pmm_pkg;
  localparam int OFFSET_BITS = 8;
  localparam int ADDRESS_BITS = 16;
  localparam int PHYS_PAGES = 256;
  localparam int PROCESSES = 8;
  localparam int VPAGE_BITS = ADDRESS_BITS - OFFSET_BITS;
  localparam int PAGE_BITS = $clog2(PHYS_PAGES);
  localparam int PID_BITS = $clog2(PROCESSES);
  localparam int MAP_DEPTH = PROCESSES << VPAGE_BITS;
  localparam int MAP_AW = PID_BITS + VPAGE_BITS;
  localparam int RAM_AW = PAGE_BITS + OFFSET_BITS;
  localparam int CNT_BITS = PAGE_BITS + 1;
  localparam int MAP_W = PAGE_BITS + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WRITE = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  process;
    logic [16:0] alloc_size;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] start_address;
    logic [7:0]  read_data;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/pmm_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered and returns the old contents on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/paged_memory_manager.sv @@
// Paged memory manager: per-process page map, page allocator and byte RAM.
// Read/write looks up the page map, then the byte store; process zero is refused at once;
// free walks the owner's page chain and then unmaps; allocate counts the free pages, then
// scans the page table for free pages to claim. One item at a time.
// After reset a clearing pass wipes the page table, the page map and the byte store;
// no item is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "paged_memory_manager_defines.svh"
module paged_memory_manager
  import pmm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [15:0] cfg_data
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_COUNT, S_COUNTW, S_ALLOC, S_ALLOCR, S_ALLOCW, S_MAPRD, S_MAPW,
    S_FREEP, S_FREEW, S_UNMAP, S_MEMRD, S_MEMW, S_DONE
  } state_t;

  state_t state;
  in_item_t req;
  logic [16:0] brk [PROCESSES];
  logic [16:0] clr_cnt;
  logic [CNT_BITS-1:0] idx, freecnt, need, done_cnt, step_cnt;
  logic [PAGE_BITS-1:0] prev, cur;
  logic [VPAGE_BITS:0] vp;
  logic have_prev;

  // Page table: owner, next pointer, last flag in one RAM.
  logic pg_we;
  logic [PAGE_BITS-1:0] pg_addr;
  logic [PAGE_BITS+3:0] pg_wd, pg_rd;
  pmm_ram #(.WIDTH(PAGE_BITS+4), .DEPTH(PHYS_PAGES)) u_page (
    .clk(clk), .we(pg_we), .addr(pg_addr), .wdata(pg_wd), .rdata(pg_rd));
  logic [2:0] rd_owner;
  logic [PAGE_BITS-1:0] rd_next;
  logic rd_last;
  assign {rd_owner, rd_next, rd_last} = pg_rd;

  logic mp_we;
  logic [MAP_AW-1:0] mp_addr;
  logic [MAP_W-1:0] mp_wd, mp_rd;
  pmm_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(mp_we), .addr(mp_addr), .wdata(mp_wd), .rdata(mp_rd));

  logic bs_we;
  logic [RAM_AW-1:0] bs_addr;
  logic [7:0] bs_wd, bs_rd;
  pmm_ram #(.WIDTH(8), .DEPTH(1 << RAM_AW)) u_bytes (
    .clk(clk), .we(bs_we), .addr(bs_addr), .wdata(bs_wd), .rdata(bs_rd));

  logic [16:0] bp;
  logic [17:0] grant_end;
  logic [CNT_BITS:0] npages;
  assign bp = brk[req.process];
  assign npages = (CNT_BITS+1)'(({1'b0, req.alloc_size} + 18'd255) >> OFFSET_BITS);
  assign grant_end = {1'b0, bp} + (18'(npages) << OFFSET_BITS);

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Memory ports driven by state.
  always_comb begin
    pg_we = 1'b0; pg_addr = idx[PAGE_BITS-1:0]; pg_wd = '0;
    mp_we = 1'b0; mp_addr = {req.process, req.address[15:OFFSET_BITS]}; mp_wd = '0;
    bs_we = 1'b0; bs_addr = {mp_rd[PAGE_BITS-1:0], req.address[OFFSET_BITS-1:0]};
    bs_wd = req.write_data;
    case (state)
      S_CLEAR: begin
        mp_we = !clr_cnt[16] && clr_cnt < 17'(MAP_DEPTH);
        mp_addr = clr_cnt[MAP_AW-1:0];
        bs_we = !clr_cnt[16];
        bs_addr = clr_cnt[RAM_AW-1:0];
        bs_wd = '0;
        pg_we = clr_cnt < 17'(PHYS_PAGES);
        pg_addr = clr_cnt[PAGE_BITS-1:0];
      end
      S_ALLOCW: begin
        if (rd_owner == 3'd0 && done_cnt < need) begin
          pg_we = 1'b1;
          pg_addr = idx[PAGE_BITS-1:0];
          pg_wd = {req.process, {PAGE_BITS{1'b0}}, 1'b1};
          mp_we = 1'b1;
          mp_addr = {req.process, VPAGE_BITS'(vp)};
          mp_wd = {1'b1, idx[PAGE_BITS-1:0]};
        end
      end
      S_MAPW: begin
        if (have_prev) begin
          pg_we = 1'b1; pg_addr = prev;
          pg_wd = {req.process, cur, 1'b0};
        end
      end
      S_FREEP: pg_addr = cur;
      S_FREEW: begin
        pg_addr = cur;
        if (rd_owner == req.process) begin
          pg_we = 1'b1; pg_wd = {3'd0, rd_next, rd_last};
        end
      end
      S_UNMAP: begin
        mp_we = !vp[VPAGE_BITS] && (done_cnt != '0);
        mp_addr = {req.process, VPAGE_BITS'(vp)};
      end
      S_MEMW: begin
        bs_we = (req.action == ACT_WRITE) && mp_rd[MAP_W-1];
      end
      default: ;
    endcase
  end

  // Sequencer and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < PROCESSES; i++) brk[i] <= 17'd256;
    end else begin
      if (cfg_we) begin
        for (int i = 0; i < PROCESSES; i++) brk[i] <= {1'b0, cfg_data};
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 17'd1;
          if (clr_cnt[16]) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_item;
            out_item <= {1'b1, 16'd0, 8'd0};
            idx <= '0; freecnt <= '0; done_cnt <= '0; step_cnt <= '0;
            have_prev <= 1'b0;
            if (in_item.process == 3'd0) state <= S_DONE;
            else if (in_item.action == ACT_ALLOC) state <= S_COUNT;
            else state <= S_MAPRD;
          end
        end
        S_COUNT: state <= S_COUNTW;
        S_COUNTW: begin
          if (rd_owner == 3'd0) freecnt <= freecnt + 1'b1;
          if (idx == CNT_BITS'(PHYS_PAGES - 1)) begin
            idx <= '0;
            state <= S_ALLOC;
            need <= npages[CNT_BITS-1:0];
            vp <= {1'b0, bp[15:OFFSET_BITS]};
          end else begin
            idx <= idx + 1'b1;
            state <= S_COUNT;
          end
        end
        S_ALLOC: begin
          if (npages == 0 || {1'b0, freecnt} < npages || grant_end > 18'h10000)
            state <= S_DONE;
          else state <= S_ALLOCW;
          freecnt <= freecnt;
        end
        S_ALLOCR: state <= S_ALLOCW;
        S_ALLOCW: begin
          if (rd_owner == 3'd0 && done_cnt < need) begin
            cur <= idx[PAGE_BITS-1:0];
            done_cnt <= done_cnt + 1'b1;
            vp <= vp + 1'b1;
            state <= S_MAPW;
          end else if (idx == CNT_BITS'(PHYS_PAGES - 1) || done_cnt >= need) begin
            brk[req.process] <= grant_end[16:0];
            out_item.status <= 1'b0;
            out_item.start_address <= bp[15:0];
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_ALLOCR;
          end
        end
        S_MAPW: begin
          prev <= cur; have_prev <= 1'b1;
          if (done_cnt >= need || idx == CNT_BITS'(PHYS_PAGES - 1)) begin
            brk[req.process] <= grant_end[16:0];
            out_item.status <= 1'b0;
            out_item.start_address <= bp[15:0];
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_ALLOCR;
          end
        end
        S_MAPRD: state <= (req.action == ACT_FREE) ? S_FREEP : S_MEMRD;
        S_FREEP: begin
          if (step_cnt == 0) begin
            if (!mp_rd[MAP_W-1]) state <= S_DONE;
            else begin
              cur <= mp_rd[PAGE_BITS-1:0];
              vp <= {1'b0, req.address[15:OFFSET_BITS]};
              out_item.status <= 1'b0;
              step_cnt <= CNT_BITS'(1);
            end
          end else state <= S_FREEW;
        end
        S_FREEW: begin
          if (rd_owner != req.process) state <= S_UNMAP;
          else begin
            done_cnt <= done_cnt + 1'b1;
            if (rd_last || step_cnt == CNT_BITS'(PHYS_PAGES)) state <= S_UNMAP;
            else begin
              cur <= rd_next; step_cnt <= step_cnt + 1'b1; state <= S_FREEP;
            end
          end
        end
        S_UNMAP: begin
          if (done_cnt == 0 || vp[VPAGE_BITS]) state <= S_DONE;
          else begin
            done_cnt <= done_cnt - 1'b1; vp <= vp + 1'b1;
          end
        end
        S_MEMRD: state <= S_MEMW;
        S_MEMW: begin
          if (mp_rd[MAP_W-1]) begin
            out_item.status <= 1'b0;
            if (req.action == ACT_READ) state <= S_DONE;
            else state <= S_DONE;
          end else state <= S_DONE;
        end
        S_DONE: begin
          if (req.action == ACT_READ && !out_item.status)
            out_item.read_data <= bs_rd;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PMM_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `PMM_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  `PMM_ASSERT_IMPL(a_no_out_clear, clk, rst, state == S_CLEAR, !out_valid)
endmodule
`default_nettype wire

@@ bench/paged_memory_manager_test.sv @@
// Self-checking bench for the paged memory manager: directed table, then random phases.
// Depends on pmm_pkg and the paged_memory_manager RTL; uses no files or arguments.
`timescale 1ns / 1ps
module paged_memory_manager_test;
  import pmm_pkg::*;

  typedef struct {
    in_item_t  req;
    bit        known;
    out_item_t res;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic cfg_we;
  logic [15:0] cfg_data;

  // Shadow copy of the block's memory system.
  logic [2:0]  page_holder [256];
  logic [7:0]  page_link [256];
  bit          page_tail [256];
  logic [8:0]  vmap [2048];
  logic [16:0] brk [8];
  logic [7:0]  ram [65536];
  logic [15:0] start_brk;

  out_item_t pending_results[$];
  row_t      rows[$];
  int        errors;
  bit        quiet_rx;

  paged_memory_manager u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20000000;
    $display("FAIL paged_memory_manager");
    $finish;
  end

  // Computes the outcome of one request and updates the shadow state.
  function automatic out_item_t apply_request(in_item_t it);
    out_item_t r;
    int pid, n, bp, freecnt, k, p, prev, vp, cnt, steps, ent;
    bit have_prev;
    r = '0;
    r.status = 1'b1;
    pid = it.process;
    if (pid != 0) begin
      case (action_t'(it.action))
        ACT_ALLOC: begin
          n = (int'(it.alloc_size) + 255) >> 8;
          bp = brk[pid];
          freecnt = 0;
          for (p = 0; p < 256; p++) if (page_holder[p] == 0) freecnt++;
          if (n != 0 && freecnt >= n && bp + (n << 8) <= 65536) begin
            k = 0;
            prev = 0;
            have_prev = 0;
            for (p = 0; p < 256 && k < n; p++) begin
              if (page_holder[p] == 0) begin
                page_holder[p] = pid[2:0];
                if (have_prev) begin
                  page_link[prev] = p[7:0];
                  page_tail[prev] = 0;
                end
                prev = p;
                have_prev = 1;
                vmap[pid * 256 + (((bp + (k << 8)) >> 8) & 255)] = {1'b1, p[7:0]};
                k++;
              end
            end
            if (have_prev) page_tail[prev] = 1;
            brk[pid] = 17'(bp + (n << 8));
            r.status = 1'b0;
            r.start_address = bp[15:0];
          end
        end
        ACT_FREE: begin
          vp = it.address[15:8];
          ent = vmap[pid * 256 + vp];
          if (ent[8]) begin
            p = ent[7:0];
            cnt = 0;
            steps = 0;
            while (steps < 256 && page_holder[p] == pid) begin
              page_holder[p] = 0;
              cnt++;
              steps++;
              if (page_tail[p]) break;
              p = page_link[p];
            end
            for (k = 0; k < cnt && vp + k < 256; k++) vmap[pid * 256 + vp + k] = '0;
            r.status = 1'b0;
          end
        end
        default: begin
          ent = vmap[pid * 256 + it.address[15:8]];
          if (ent[8]) begin
            if (action_t'(it.action) == ACT_READ) r.read_data = ram[{ent[7:0], it.address[7:0]}];
            else ram[{ent[7:0], it.address[7:0]}] = it.write_data;
            r.status = 1'b0;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic in_item_t mk(action_t a, int pid, int size, int addr, int data);
    in_item_t it;
    it.action = a;
    it.process = pid[2:0];
    it.alloc_size = size[16:0];
    it.address = addr[15:0];
    it.write_data = data[7:0];
    return it;
  endfunction

  function automatic out_item_t res(bit st, int sa, int rd);
    out_item_t r;
    r.status = st;
    r.start_address = sa[15:0];
    r.read_data = rd[7:0];
    return r;
  endfunction

  task automatic add_row(in_item_t it, bit known, out_item_t r);
    row_t rw;
    rw.req = it;
    rw.known = known;
    rw.res = r;
    rows.push_back(rw);
  endtask

  task automatic report_mismatch(string fld, int got, int want);
    $display("mismatch on %s: got %0h, expected %0h", fld, got, want);
    errors++;
  endtask

  // Drives one item and records its expected result on acceptance.
  task automatic send_item(in_item_t it, bit known, out_item_t typed);
    out_item_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(it);
    pending_results.push_back(known ? typed : predicted);
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write; the block reloads every break pointer.
  task automatic write_break(logic [15:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    start_brk = v;
    for (int i = 0; i < 8; i++) brk[i] = {1'b0, v};
  endtask

  function automatic in_item_t random_request();
    in_item_t it;
    logic [63:0] raw;
    int sel, pid, lo, hi;
    sel = $urandom_range(0, 99);
    pid = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 7);
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.process = pid[2:0];
    if (sel < 15) it.action = ACT_ALLOC;
    else if (sel < 25) it.action = ACT_FREE;
    else if (sel < 60) it.action = ACT_READ;
    else it.action = ACT_WRITE;
    // Mostly small sizes, with an occasional zero or huge request.
    if ($urandom_range(0, 19) == 0) it.alloc_size = ($urandom_range(0, 1) == 0) ? 17'd0 :
                                                  17'($urandom_range(1024, 65536));
    else it.alloc_size = 17'($urandom_range(1, 1024));
    // Mostly aim at the region granted since the last break reload.
    lo = start_brk;
    hi = brk[pid] - 1;
    if (hi >= lo && $urandom_range(0, 99) < 85) it.address = 16'($urandom_range(lo, hi));
    return it;
  endfunction

  // Receiver stall pattern, with stretches of no stalls.
  initial begin
    int run;
    out_ready = 1'b0;
    forever begin
      run = $urandom_range(1, 10);
      repeat (run) begin
        @(negedge clk);
        out_ready <= quiet_rx ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
      if (!quiet_rx) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
  end

  // Result checker.
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("result with nothing outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", out_item.status, want.status);
          if (out_item.start_address !== want.start_address)
            report_mismatch("start_address", out_item.start_address, want.start_address);
          if (out_item.read_data !== want.read_data)
            report_mismatch("read_data", out_item.read_data, want.read_data);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    logic [15:0] phase_brk [5];
    int burst;
    bit steady;
    out_item_t none;
    errors = 0;
    quiet_rx = 0;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < 256; i++) begin
      page_holder[i] = '0;
      page_link[i] = '0;
      page_tail[i] = 0;
    end
    for (int i = 0; i < 2048; i++) vmap[i] = '0;
    for (int i = 0; i < 65536; i++) ram[i] = '0;
    start_brk = 16'd256;
    for (int i = 0; i < 8; i++) brk[i] = 17'd256;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: edges, every action, and each failure path.
    add_row(mk(ACT_READ, 1, 0, 16'h0100, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_ALLOC, 0, 16, 0, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_ALLOC, 1, 0, 0, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_ALLOC, 1, 65536, 0, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_ALLOC, 7, 17'h1FFFF, 0, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_ALLOC, 1, 1, 0, 0), 1, res(0, 256, 0));
    add_row(mk(ACT_WRITE, 1, 0, 16'h0100, 8'hFF), 1, res(0, 0, 0));
    add_row(mk(ACT_READ, 1, 0, 16'h0100, 0), 1, res(0, 0, 8'hFF));
    add_row(mk(ACT_READ, 1, 0, 16'h0200, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_WRITE, 7, 0, 16'h0100, 8'h55), 1, res(1, 0, 0));
    add_row(mk(ACT_WRITE, 0, 0, 16'h0100, 8'h55), 1, res(1, 0, 0));
    add_row(mk(ACT_ALLOC, 7, 300, 0, 0), 0, none);
    add_row(mk(ACT_WRITE, 7, 0, 16'h01FF, 8'hA5), 0, none);
    add_row(mk(ACT_WRITE, 7, 0, 16'h0200, 8'h00), 0, none);
    add_row(mk(ACT_READ, 7, 0, 16'h01FF, 0), 0, none);
    add_row(mk(ACT_READ, 7, 0, 16'h0200, 0), 0, none);
    add_row(mk(ACT_ALLOC, 3, 257, 0, 0), 0, none);
    add_row(mk(ACT_FREE, 7, 0, 16'h0100, 0), 0, none);
    add_row(mk(ACT_FREE, 7, 0, 16'h0100, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_FREE, 1, 0, 16'hFFFF, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_READ, 7, 0, 16'h0200, 0), 1, res(1, 0, 0));
    add_row(mk(ACT_ALLOC, 5, 512, 0, 0), 0, none);
    add_row(mk(ACT_FREE, 3, 0, 16'h0200, 0), 0, none);
    add_row(mk(ACT_READ, 1, 0, 16'h01FF, 0), 1, res(0, 0, 0));
    foreach (rows[i]) send_item(rows[i].req, rows[i].known, rows[i].res);
    idle_cycles(0);

    // The sender holds off here until every result is back.
    drain();

    // Random phases, each under its own break setting.
    phase_brk[0] = 16'h0000;
    phase_brk[1] = 16'hFFFF;
    phase_brk[2] = 16'hFF00;
    phase_brk[3] = 16'h0100;
    phase_brk[4] = 16'h8000;
    for (int ph = 0; ph < 5; ph++) begin
      write_break(phase_brk[ph]);
      steady = (ph == 3);
      quiet_rx = (ph == 4);
      for (int n = 0; n < 80; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 80; b++, n++) send_item(random_request(), 0, none);
        if (!steady) idle_cycles($urandom_range(0, 6));
      end
      idle_cycles(0);
      drain();
    end
    quiet_rx = 0;

    if (errors == 0) begin
      $display("PASS paged_memory_manager");
    end else begin
      $display("FAIL paged_memory_manager");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/pmm_pkg.sv
rtl/pmm_ram.sv
rtl/paged_memory_manager.sv
bench/paged_memory_manager_test.sv
